// File: rtl/tafl_pkg.sv
// Package for the three-axis FIR low-pass filter.
// Holds the coefficient table, the control word types and the microcode program.
// No dependencies.
`default_nettype none

package tafl_pkg;

    // Half of the symmetric coefficient set in Q1.15; the center tap is last.
    localparam int HALF_LEN = 10;
    localparam logic signed [15:0] HALF_COEF [HALF_LEN] = '{
        -16'sd157, 16'sd0, 16'sd508, 16'sd609, -16'sd498,
        -16'sd1943, -16'sd1130, 16'sd3424, 16'sd9440, 16'sd12252
    };

    // Coefficient of tap k for a filter of the given length, aligned on the center.
    function automatic logic signed [15:0] coef_at(input int k, input int taps);
        int m;
        int idx;
        m   = (k < taps - 1 - k) ? k : (taps - 1 - k);
        idx = (HALF_LEN - 1) - (((taps - 1) >> 1) - m);
        if (idx < 0 || idx >= HALF_LEN)
            return 16'sd0;
        return HALF_COEF[idx];
    endfunction

    // Steps of the microcode program.
    typedef enum logic [2:0] {
        ST_WAIT  = 3'd0,
        ST_MULN  = 3'd1,
        ST_MULH  = 3'd2,
        ST_DRAIN = 3'd3,
        ST_OUT   = 3'd4
    } step_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        JC_NONE     = 3'd0,
        JC_NO_IN    = 3'd1,
        JC_DONE     = 3'd2,
        JC_MORE     = 3'd3,
        JC_OUT_BUSY = 3'd4
    } jcond_t;

    // Datapath controls shared by the three axis units.
    typedef struct packed {
        logic load_smp;
        logic mul_en;
        logic mul_hist;
        logic rot;
        logic acc_clr;
        logic acc_en;
        logic shift_in;
    } ctrl_t;

    // One control word of the program.
    typedef struct packed {
        ctrl_t  ctrl;
        logic   in_rdy;
        logic   out_ld;
        logic   k_clr;
        logic   k_inc;
        jcond_t jc;
        step_t  tgt;
        step_t  nxt;
    } ucode_t;

    // Program ROM.
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t uc;
        uc = '0;
        uc.jc  = JC_NONE;
        uc.tgt = ST_WAIT;
        uc.nxt = ST_WAIT;
        case (pc)
            ST_WAIT:
            begin
                uc.in_rdy        = 1'b1;
                uc.ctrl.load_smp = 1'b1;
                uc.k_clr         = 1'b1;
                uc.jc            = JC_NO_IN;
                uc.tgt           = ST_WAIT;
                uc.nxt           = ST_MULN;
            end
            ST_MULN:
            begin
                uc.ctrl.mul_en  = 1'b1;
                uc.ctrl.acc_clr = 1'b1;
                uc.k_inc        = 1'b1;
                uc.jc           = JC_DONE;
                uc.tgt          = ST_DRAIN;
                uc.nxt          = ST_MULH;
            end
            ST_MULH:
            begin
                uc.ctrl.mul_en   = 1'b1;
                uc.ctrl.mul_hist = 1'b1;
                uc.ctrl.rot      = 1'b1;
                uc.ctrl.acc_en   = 1'b1;
                uc.k_inc         = 1'b1;
                uc.jc            = JC_MORE;
                uc.tgt           = ST_MULH;
                uc.nxt           = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                uc.ctrl.acc_en   = 1'b1;
                uc.ctrl.shift_in = 1'b1;
                uc.nxt           = ST_OUT;
            end
            ST_OUT:
            begin
                uc.out_ld = 1'b1;
                uc.jc     = JC_OUT_BUSY;
                uc.tgt    = ST_OUT;
                uc.nxt    = ST_WAIT;
            end
            default:
            begin
                uc.nxt = ST_WAIT;
            end
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

// File: rtl/three_axis_fir_lowpass.sv
// Top level of the three-axis symmetric FIR low-pass filter.
// Microcoded sequencer driving three tafl_mac units; depends on tafl_pkg.
//
// Channel   Dir  Handshake           Payload
// s_axis    in   s_tvalid/s_tready   s_tdata: accel_x, accel_y, accel_z
// m_axis    out  m_tvalid/m_tready   m_tdata: filt_x, filt_y, filt_z
//
// Each item is computed by the single multiplier per axis stepping through one
// tap per cycle. Reset clears the delay lines, the sequencer and the output
// valid flag. A finished result waits in the output register while the next
// item is accepted and computed; the program stalls at its output step only if
// the previous result has not yet been taken.
`default_nettype none

module three_axis_fir_lowpass #(
    parameter int TAPS        = 19,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: accel_x, accel_y, accel_z, zero padding.
    input  wire  [((3 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // Fields from bit 0 up: filt_x, filt_y, filt_z, zero padding.
    output logic [((3 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
    import tafl_pkg::*;

    localparam int DW = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int KW = $clog2(TAPS + 1);

    step_t                         pc_reg, pc_next;
    ucode_t                        uc;
    ctrl_t                         ctrl;
    logic [KW-1:0]                 k_reg, k_next, k_inc;
    logic                          taken;
    logic                          out_busy;
    logic                          out_fire;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [3*SAMPLE_BITS-1:0]      res_reg;
    logic signed [15:0]            coef;
    logic signed [SAMPLE_BITS-1:0] res [3];

    // Control word of the current step.
    always_comb
    begin
        uc            = ucode_rom(pc_reg);
        ctrl          = uc.ctrl;
        ctrl.load_smp = uc.ctrl.load_smp & s_tvalid;
        s_tready      = uc.in_rdy;
        out_busy      = m_tvalid_reg & ~m_tready;
        out_fire      = uc.out_ld & ~out_busy;
    end

    // Next step: conditional jump or fall-through.
    always_comb
    begin
        k_inc = k_reg + 1'b1;
        case (uc.jc)
            JC_NONE:     taken = 1'b0;
            JC_NO_IN:    taken = ~s_tvalid;
            JC_DONE:     taken = (k_inc == KW'(TAPS));
            JC_MORE:     taken = (k_inc != KW'(TAPS));
            JC_OUT_BUSY: taken = out_busy;
            default:     taken = 1'b0;
        endcase
        pc_next = taken ? uc.tgt : uc.nxt;
        if (uc.k_clr)
            k_next = '0;
        else if (uc.k_inc)
            k_next = k_inc;
        else
            k_next = k_reg;
        if (out_fire)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // Step counter, tap counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= ST_WAIT;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Coefficient for the current tap.
    assign coef = coef_at(int'(k_reg), TAPS);

    // One datapath per axis.
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        tafl_mac #(
            .TAPS        (TAPS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_mac (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .coef   (coef),
            .smp_in (s_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]),
            .result (res[a])
        );
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_fire)
            res_reg <= {res[2], res[1], res[0]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'(res_reg);

    // An accepted item always starts with the first product step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (pc_reg == ST_MULN))
        else $error("accepted item did not start the multiply sequence");

    // The history loop only runs on taps that exist.
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == ST_MULH) |-> (k_reg != '0 && k_reg < KW'(TAPS)))
        else $error("tap counter out of range in history loop");

    // A new result appears only from the output step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(pc_reg) == ST_OUT))
        else $error("result became valid outside the output step");

    // No item is taken while the program is busy.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (pc_reg == ST_WAIT))
        else $error("input ready outside the wait step");

endmodule

`default_nettype wire

// File: rtl/tafl_mac.sv
// One axis of the filter: delay line, shared multiplier and accumulator.
// Depends on tafl_pkg for the control struct.
`default_nettype none

module tafl_mac #(
    parameter int TAPS        = 19,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  tafl_pkg::ctrl_t              ctrl,
    input  wire signed [15:0]            coef,
    input  wire signed [SAMPLE_BITS-1:0] smp_in,
    output logic signed [SAMPLE_BITS-1:0] result
);
    import tafl_pkg::*;

    localparam int HL     = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int PROD_W = SAMPLE_BITS + 16;
    localparam int ACC_W  = PROD_W + $clog2(TAPS + 1) + 1;
    localparam int RW     = ACC_W + 1 - 15;
    localparam logic signed [RW-1:0] HI = RW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] LO = RW'(-(2 ** (SAMPLE_BITS - 1)));

    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic signed [SAMPLE_BITS-1:0] sh_reg [HL];
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [SAMPLE_BITS-1:0] op;
    logic signed [ACC_W:0]         rnd;
    logic signed [RW-1:0]          shr;

    // New sample register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_smp)
            smp_reg <= smp_in;
    end

    // Delay line: rotates once per history tap, then takes the new sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HL; i++)
                sh_reg[i] <= '0;
        end
        else if (ctrl.rot)
        begin
            for (int i = 0; i < HL - 1; i++)
                sh_reg[i] <= sh_reg[i + 1];
            sh_reg[HL-1] <= sh_reg[0];
        end
        else if (ctrl.shift_in)
        begin
            for (int i = 1; i < HL; i++)
                sh_reg[i] <= sh_reg[i - 1];
            sh_reg[0] <= smp_reg;
        end
    end

    // Multiplier operand: the new sample first, then the stored samples from
    // newest to oldest as the delay line rotates.
    assign op = ctrl.mul_hist ? sh_reg[0] : smp_reg;

    // Registered product, then accumulate.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= PROD_W'(coef) * PROD_W'(op);
        if (ctrl.acc_clr)
            acc_reg <= '0;
        else if (ctrl.acc_en)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Round half up, shift by 15 and saturate.
    always_comb
    begin
        rnd = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(16384);
        shr = RW'(rnd >>> 15);
        if (shr > HI)
            result = HI[SAMPLE_BITS-1:0];
        else if (shr < LO)
            result = LO[SAMPLE_BITS-1:0];
        else
            result = shr[SAMPLE_BITS-1:0];
    end

endmodule

`default_nettype wire
